>>> hdl/ddo_pkg.sv
// shared types, constants and the arctangent table for the odometry block
// no dependencies
package ddo_pkg;

   localparam int HEADING_W = 17;
   localparam int POS_W     = 32;
   localparam int ANGLE_W   = 32;
   localparam int CORDIC_W  = 34;
   localparam int TRIG_W    = 18;
   localparam int ATAN_IDX_W = 5;

   // heading to binary angle: q = floor((deg_q8 * 2^21 + 22) / 45), biased positive
   localparam int ANG_NUM_W = 39;
   localparam int ANG_SHIFT = 21;
   localparam logic [ANG_NUM_W-1:0] ANG_BIAS = 39'd193273528342;
   localparam logic [6:0] ANG_DIV = 7'd45;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_ROTATE,
      ST_MULX,
      ST_MULY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic angle_start;
      logic rotate_start;
      logic mul_start;
      logic mul_sel_sin;
      logic mul_sel_travel;
   } ctl_type;

   function automatic logic [29:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2FA;
         5'd15: v = 30'h0000517D;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A30;
         5'd19: v = 30'h00000518;
         5'd20: v = 30'h0000028C;
         5'd21: v = 30'h00000146;
         5'd22: v = 30'h000000A3;
         5'd23: v = 30'h00000051;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/diff_drive_odometry_top.sv
// differential drive odometry top level: sequencer, state and output register
// depends on ddo_pkg, ddo_adiv, ddo_cordic, ddo_smul
//
//   channel   direction   handshake              contents
//   req_      in          tvalid/tready          right_count, left_count, heading_deg
//   rsp_      out         tvalid/tready          x_pos, y_pos
//   csr_      in          wr_en                  mm_per_pulse
//
// an item runs from one accept to the next through the serial divider for the angle,
// the cordic rotations, two 18-bit serial multiplies and the output load; the travel
// multiply overlaps the angle division.
// reset clears positions, previous counts and mm_per_pulse to its default.
// a result waits in the output register while the next item is taken; only the
// final write of that next item waits for rsp_tready.
module diff_drive_odometry_top #(
   parameter int CORDIC_STEPS = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [31:0] right_count, [63:32] left_count, [80:64] heading_deg, [87:81] zero
   input  logic [87:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [31:0] x_pos, [63:32] y_pos
   output logic [63:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   localparam int SUM_W = COUNT_BITS + 1;
   localparam int BW = ddo_pkg::TRIG_W;
   localparam int CENTRE_W = SUM_W + BW + 1 - 9;
   localparam int PW = CENTRE_W + BW;
   localparam int PW_W = ddo_pkg::POS_W;

   ddo_pkg::state_type state_ff, state_in;
   ddo_pkg::ctl_type ctl;

   logic [15:0] mm_ff;
   logic [COUNT_BITS-1:0] prev_r_ff, prev_l_ff, right, left, dr, dl;
   logic signed [SUM_W-1:0] sum;
   logic signed [PW_W-1:0] x_acc_ff, y_acc_ff, x_out_ff, y_out_ff;
   logic rsp_valid_ff;
   logic signed [CENTRE_W-1:0] centre_ff;
   logic signed [BW-1:0] cos_now, sin_ff, cos_r, sin_r;
   logic accept, out_free, flip;

   logic [ddo_pkg::ANGLE_W-1:0] angle, folded;
   logic angle_busy, rot_busy, mul_busy;
   logic signed [ddo_pkg::CORDIC_W-1:0] cx, cy;
   logic signed [CENTRE_W-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] prod, prod_rnd, delta_acc;
   logic signed [PW-1:0] max_pos, min_pos;
   logic signed [PW_W-1:0] acc_sel, acc_sat;

   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign right = req_tdata[COUNT_BITS-1:0];
   assign left = COUNT_BITS'(0) - req_tdata[32 +: COUNT_BITS];
   assign dr = right - prev_r_ff;
   assign dl = left - prev_l_ff;
   assign sum = SUM_W'($signed(dr)) + SUM_W'($signed(dl));

   // second and third quadrants turn by half a circle and negate afterwards
   assign flip = angle[31] ^ angle[30];
   assign folded = {angle[31] ^ flip, angle[30:0]};

   assign cos_r = BW'((cx + ddo_pkg::CORDIC_W'(16384)) >>> 15);
   assign sin_r = BW'((cy + ddo_pkg::CORDIC_W'(16384)) >>> 15);
   assign cos_now = flip ? -cos_r : cos_r;

   // the cosine multiply starts in the cycle the rotations finish
   assign mul_a = ctl.mul_sel_travel ? CENTRE_W'(sum) : centre_ff;
   assign mul_b = ctl.mul_sel_travel ? BW'({1'b0, mm_ff})
                                     : (ctl.mul_sel_sin ? sin_ff : cos_now);

   ddo_adiv u_adiv (
      .clock(clock), .reset(reset), .start(ctl.angle_start),
      .heading(req_tdata[64 +: ddo_pkg::HEADING_W]), .angle(angle), .busy(angle_busy)
   );

   ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(ctl.rotate_start), .angle(folded),
      .x_out(cx), .y_out(cy), .busy(rot_busy)
   );

   ddo_smul #(.AW(CENTRE_W), .BW(BW)) u_smul (
      .clock(clock), .reset(reset), .start(ctl.mul_start), .a(mul_a), .b(mul_b),
      .product(prod), .busy(mul_busy)
   );

   assign prod_rnd = (prod + PW'(16384)) >>> 15;
   assign acc_sel = (state_ff == ddo_pkg::ST_MULY) ? y_acc_ff : x_acc_ff;
   assign delta_acc = PW'(acc_sel) + prod_rnd;
   assign max_pos = PW'({1'b0, {(PW_W-1){1'b1}}});
   assign min_pos = -max_pos - PW'(1);

   always_comb begin
      priority if (delta_acc > max_pos) begin
         acc_sat = {1'b0, {(PW_W-1){1'b1}}};
      end else if (delta_acc < min_pos) begin
         acc_sat = {1'b1, {(PW_W-1){1'b0}}};
      end else begin
         acc_sat = PW_W'(delta_acc);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddo_pkg::ST_IDLE:   if (accept) state_in = ddo_pkg::ST_ANGLE;
         ddo_pkg::ST_ANGLE:  if (!angle_busy && !mul_busy) state_in = ddo_pkg::ST_ROTATE;
         ddo_pkg::ST_ROTATE: if (!rot_busy) state_in = ddo_pkg::ST_MULX;
         ddo_pkg::ST_MULX:   if (!mul_busy) state_in = ddo_pkg::ST_MULY;
         ddo_pkg::ST_MULY:   if (!mul_busy) state_in = ddo_pkg::ST_DONE;
         ddo_pkg::ST_DONE:   if (out_free) state_in = ddo_pkg::ST_IDLE;
         default:            state_in = ddo_pkg::ST_IDLE;
      endcase
   end

   // unit controls
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ddo_pkg::ST_IDLE: begin
            ctl.angle_start = accept;
            ctl.mul_start = accept;
            ctl.mul_sel_travel = 1'b1;
         end
         ddo_pkg::ST_ANGLE: begin
            ctl.rotate_start = !angle_busy && !mul_busy;
         end
         ddo_pkg::ST_ROTATE: begin
            ctl.mul_start = !rot_busy;
         end
         ddo_pkg::ST_MULX: begin
            ctl.mul_start = !mul_busy;
            ctl.mul_sel_sin = 1'b1;
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ddo_pkg::ST_ANGLE) begin
         centre_ff <= CENTRE_W'((prod + PW'(256)) >>> 9);
      end
      if (state_ff == ddo_pkg::ST_ROTATE && !rot_busy) begin
         sin_ff <= flip ? -sin_r : sin_r;
      end
      if (state_ff == ddo_pkg::ST_DONE && out_free) begin
         x_out_ff <= x_acc_ff;
         y_out_ff <= y_acc_ff;
      end
      if (reset) begin
         state_ff <= ddo_pkg::ST_IDLE;
         mm_ff <= 16'd44119;
         prev_r_ff <= '0;
         prev_l_ff <= '0;
         x_acc_ff <= '0;
         y_acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            mm_ff <= csr_wr_data;
         end
         if (accept) begin
            prev_r_ff <= right;
            prev_l_ff <= left;
         end
         if (state_ff == ddo_pkg::ST_MULX && !mul_busy) begin
            x_acc_ff <= acc_sat;
         end
         if (state_ff == ddo_pkg::ST_MULY && !mul_busy) begin
            y_acc_ff <= acc_sat;
         end
         if (state_ff == ddo_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == ddo_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {y_out_ff, x_out_ff};
endmodule

>>> hdl/ddo_adiv.sv
// bit-serial heading to binary angle converter, restoring division by 45
// depends on ddo_pkg
module ddo_adiv (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [ddo_pkg::HEADING_W-1:0] heading,
   output logic [ddo_pkg::ANGLE_W-1:0] angle,
   output logic busy
);
   localparam int NW = ddo_pkg::ANG_NUM_W;
   localparam int CW = $clog2(NW);

   logic [NW-1:0] num_ff, num_in;
   logic [5:0] rem_ff, rem_in;
   logic [ddo_pkg::ANGLE_W-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic signed [NW-1:0] head_ext;
   logic [6:0] trial;
   logic ge;

   assign head_ext = NW'(heading);
   assign trial = {rem_ff, num_ff[NW-1]};
   assign ge = (trial >= ddo_pkg::ANG_DIV);

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in = (head_ext <<< ddo_pkg::ANG_SHIFT) + ddo_pkg::ANG_BIAS;
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         rem_in = ge ? 6'(trial - ddo_pkg::ANG_DIV) : trial[5:0];
         quo_in = {quo_ff[ddo_pkg::ANGLE_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW-1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign angle = quo_ff;
   assign busy = busy_ff;
endmodule

>>> hdl/ddo_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on ddo_pkg
module ddo_cordic #(
   parameter int STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [ddo_pkg::ANGLE_W-1:0] angle,
   output logic signed [ddo_pkg::CORDIC_W-1:0] x_out,
   output logic signed [ddo_pkg::CORDIC_W-1:0] y_out,
   output logic busy
);
   localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic signed [ddo_pkg::CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ddo_pkg::ANGLE_W-1:0] z_ff, z_in, at;
   logic [CW-1:0] step_ff, step_in;
   logic busy_ff, busy_in;

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign at = ddo_pkg::ANGLE_W'(ddo_pkg::atan_bam(ddo_pkg::ATAN_IDX_W'(step_ff)));

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in = ddo_pkg::CORDIC_GAIN;
         y_in = '0;
         z_in = angle;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[ddo_pkg::ANGLE_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == CW'(STEPS-1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign busy = busy_ff;
endmodule

>>> hdl/ddo_smul.sv
// serial signed multiplier, one multiplier bit per cycle
// depends on nothing but its parameters
module ddo_smul #(
   parameter int AW = 42,
   parameter int BW = 18
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] product,
   output logic busy
);
   localparam int PW = AW + BW;
   localparam int CW = $clog2(BW);

   logic signed [PW-1:0] acc_ff, acc_in, a_sh_ff, a_sh_in, addend;
   logic [BW-1:0] b_sh_ff, b_sh_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;

   assign addend = b_sh_ff[0] ? a_sh_ff : '0;

   always_comb begin
      acc_in = acc_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in = '0;
         a_sh_in = PW'(a);
         b_sh_in = b;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // the top multiplier bit carries negative weight
         if (cnt_ff == CW'(BW-1)) begin
            acc_in = acc_ff - addend;
            busy_in = 1'b0;
         end else begin
            acc_in = acc_ff + addend;
         end
         a_sh_in = a_sh_ff <<< 1;
         b_sh_in = b_sh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign product = acc_ff;
   assign busy = busy_ff;
endmodule

>>> hdl/ddo_checker.sv
// port-level checks for the odometry top level, attached by bind
// depends on diff_drive_odometry_top
module ddo_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [63:0] rsp_tdata
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after an item");

   a_busy_at_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result issued while the block was idle");

   a_ready_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("block not ready once a result is issued");
endmodule

bind diff_drive_odometry_top ddo_checker u_ddo_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

>>> dv/diff_drive_odometry_checker.sv
// scoreboard for the odometry block: watches the item, result and csr channels, predicts positions
// depends on ddo_pkg only for widths; the prediction is written out here
module diff_drive_odometry_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [87:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int fail_count,
   output int pending
);
   typedef struct packed {
      logic signed [ddo_pkg::POS_W-1:0] y_pos;
      logic signed [ddo_pkg::POS_W-1:0] x_pos;
   } pos_type;

   localparam int STEPS = 16;
   localparam longint P_MAX = 64'sd2147483647;
   localparam longint P_MIN = -64'sd2147483648;

   logic [15:0] scale;
   logic [31:0] last_right, last_left;
   longint x_track, y_track;
   pos_type positions_due[$];

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint shr_round(longint v, int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > P_MAX) return P_MAX;
      if (v < P_MIN) return P_MIN;
      return v;
   endfunction

   function automatic longint atan_step(int i);
      case (i)
         0: return 64'h20000000;  1: return 64'h12E4051E;  2: return 64'h09FB385B;
         3: return 64'h051111D4;  4: return 64'h028B0D43;  5: return 64'h0145D7E1;
         6: return 64'h00A2F61E;  7: return 64'h00517C55;  8: return 64'h0028BE53;
         9: return 64'h00145F2F; 10: return 64'h000A2F98; 11: return 64'h000517CC;
         12: return 64'h00028BE6; 13: return 64'h000145F3; 14: return 64'h0000A2FA;
         default: return 64'h0000517D;
      endcase
   endfunction

   task automatic heading_trig(input logic [16:0] raw, output longint c, output longint s);
      longint d, n, q, z, x, y, xn, xs, ys;
      logic [31:0] ang;
      bit flip;
      d = longint'($signed(raw));
      n = d * 64'sd4294967296 + 46080;
      if (n >= 0) q = n / 92160;
      else q = -((-n + 92159) / 92160);
      ang = q[31:0];
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang + 32'h80000000;
      z = longint'($signed(ang));
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (z >= 0) begin
            xn = x - ys; y = y + xs; z = z - atan_step(i);
         end else begin
            xn = x + ys; y = y - xs; z = z + atan_step(i);
         end
         x = xn;
      end
      c = shr_round(x, 15);
      s = shr_round(y, 15);
      if (flip) begin
         c = -c; s = -s;
      end
   endtask

   task automatic advance_position(input logic [87:0] item);
      logic [31:0] r, l;
      longint dr, dl, travel, c, s;
      pos_type p;
      r = item[31:0];
      l = -item[63:32];
      dr = longint'($signed(r - last_right));
      dl = longint'($signed(l - last_left));
      last_right = r;
      last_left = l;
      travel = shr_round((dr + dl) * longint'(scale), 9);
      heading_trig(item[80:64], c, s);
      x_track = clamp32(x_track + shr_round(travel * c, 15));
      y_track = clamp32(y_track + shr_round(travel * s, 15));
      p.x_pos = x_track[31:0];
      p.y_pos = y_track[31:0];
      positions_due.push_back(p);
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      pos_type got, want;
      if (reset) begin
         scale <= 16'd44119;
         last_right = '0;
         last_left = '0;
         x_track = 0;
         y_track = 0;
         positions_due.delete();
      end else begin
         if (req_tvalid && req_tready) advance_position(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (positions_due.size() == 0) begin
               report("unexpected item", got.x_pos, 0);
            end else begin
               want = positions_due.pop_front();
               if (got.x_pos !== want.x_pos) report("x_pos", got.x_pos, want.x_pos);
               if (got.y_pos !== want.y_pos) report("y_pos", got.y_pos, want.y_pos);
            end
         end
         if (csr_wr_en) scale <= csr_wr_data;
      end
      pending = positions_due.size();
   end
endmodule

>>> dv/diff_drive_odometry_top_tb.sv
// testbench top for the odometry block: clock, reset, stimulus, configuration and verdict
// depends on diff_drive_odometry_top and diff_drive_odometry_checker
module diff_drive_odometry_top_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [87:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   int fail_count, pending;
   int idle_cycles = 0;
   int rsp_idle = 0;
   bit quiet = 1'b0;
   bit hold_rsp = 1'b0;
   logic [31:0] right_now = '0, left_now = '0;

   localparam int WATCHDOG = 20000;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   diff_drive_odometry_top i_dut (.*);

   diff_drive_odometry_checker i_checker (.*);

   // receiver stalls in random bursts, or a long hold when asked, and is always ready when quiet
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_idle > 0) begin
         rsp_tready <= 1'b0;
         rsp_idle <= rsp_idle - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_idle <= $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // valid stays up after an accept so the next item can follow without a second drive
   task automatic send_item(input logic [31:0] r, input logic [31:0] l, input logic [16:0] h);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, h, l, r};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic req_idle();
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_and_write(input logic [15:0] v);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [16:0] any_heading();
      case ($urandom_range(0, 7))
         0: return 17'($urandom());
         1: return 17'($urandom_range(0, 8) * 11520);
         2: return -17'($urandom_range(0, 8) * 11520);
         default: return 17'($signed($urandom_range(0, 92160)) - 46080);
      endcase
   endfunction

   // mostly small steps from the current counts, now and then large jumps
   task automatic random_move();
      if ($urandom_range(0, 9) == 0) begin
         right_now = $urandom();
         left_now = $urandom();
      end else begin
         right_now = right_now + 32'($signed($urandom_range(0, 4000)) - 2000);
         left_now = left_now + 32'($signed($urandom_range(0, 4000)) - 2000);
      end
      send_item(right_now, left_now, any_heading());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: heading extremes and quadrant edges, count extremes and wrap
      send_item(32'd0, 32'd0, 17'd0);
      send_item(32'd1000, -32'd1000, 17'd0);
      send_item(32'd2000, -32'd2000, 17'd23040);
      send_item(32'd3000, -32'd3000, -17'd23040);
      send_item(32'd4000, -32'd4000, 17'd46080);
      send_item(32'd5000, -32'd5000, -17'd46080);
      send_item(32'd6000, -32'd6000, 17'h0FFFF);
      send_item(32'd7000, -32'd7000, 17'h10000);
      send_item(32'd8000, -32'd8000, 17'h1FFFF);
      send_item(32'h7FFFFFFF, 32'h80000000, 17'd11520);
      send_item(32'h80000000, 32'h7FFFFFFF, -17'd34560);
      send_item(32'hFFFFFFFF, 32'h00000001, 17'd34560);
      send_item(32'h7FFFFFFF, 32'h80000001, 17'd100);
      send_item(32'd0, 32'd0, 17'd0);
      req_idle();
      drain_and_write(16'hFFFF);
      // drive x toward positive saturation, then y toward negative saturation
      for (int i = 0; i < 12; i++) begin
         right_now = right_now + 32'h40000000 - 1;
         left_now = left_now - 32'h40000000 + 1;
         send_item(right_now, left_now, 17'd0);
      end
      for (int i = 0; i < 12; i++) begin
         right_now = right_now - 32'h40000000 + 1;
         left_now = left_now + 32'h40000000 - 1;
         send_item(right_now, left_now, 17'd23040);
      end
      req_idle();
      drain_and_write(16'd0);
      for (int i = 0; i < 10; i++) random_move();
      // receiver holds off while items keep coming
      hold_rsp = 1'b1;
      fork
         begin
            for (int i = 0; i < 6; i++) random_move();
            req_idle();
         end
         begin
            repeat (800) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join
      drain_and_write(16'd1);
      for (int i = 0; i < 150; i++) random_move();
      req_idle();
      drain_and_write(16'd44119);
      for (int i = 0; i < 200; i++) random_move();
      req_idle();
      drain_and_write(16'($urandom()));
      for (int i = 0; i < 150; i++) random_move();
      quiet = 1'b1;
      for (int i = 0; i < 100; i++) random_move();
      req_idle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

>>> sim.f
hdl/ddo_pkg.sv
hdl/ddo_adiv.sv
hdl/ddo_cordic.sv
hdl/ddo_smul.sv
hdl/diff_drive_odometry_top.sv
hdl/ddo_checker.sv
dv/diff_drive_odometry_checker.sv
dv/diff_drive_odometry_top_tb.sv
